// ----- sv/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define DFL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DFL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/dfl_pkg.sv -----
// Shared types and constants for the descriptor free list allocator.
package dfl_pkg;

    localparam int POOL_DEPTH  = 1024;
    localparam int SLOT_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W       = $clog2(POOL_DEPTH + 1);
    localparam int REV_W       = 32;
    localparam int ADDR_W      = 48;
    localparam int INC_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 48;

    localparam int RESET_COUNT_RAW = 1024;
    localparam logic [CNT_W-1:0] RESET_COUNT =
        CNT_W'((RESET_COUNT_RAW > POOL_DEPTH) ? POOL_DEPTH : RESET_COUNT_RAW);
    localparam logic [INC_W-1:0] RESET_INC = INC_W'(32);

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INCREMENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] free_index;
        logic              handle_valid;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [REV_W-1:0]  revision;
        logic [ADDR_W-1:0] cpu_address;
        logic [CNT_W-1:0]  slack;
    } t_out;

    // Clearing sweep control, shared by both memories.
    typedef struct packed {
        logic              active;
        logic [SLOT_W-1:0] idx;
    } t_clr;

    typedef struct packed {
        logic              is_alloc;
        t_status           status;
        logic [SLOT_W-1:0] free_index;
        logic [CNT_W-1:0]  slack;
    } t_s1;

    typedef struct packed {
        logic              is_alloc;
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  slack;
    } t_s2;

endpackage

// ----- sv/dfl_free_queue.sv -----
// FIFO of free slot numbers with head/tail pointers, free count and admission check.
module dfl_free_queue import dfl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_clr              i_clr,
    input  logic              i_init,
    input  logic [CNT_W-1:0]  i_init_count,
    input  logic [CNT_W-1:0]  i_live_count,
    input  logic              i_take,
    input  t_in               i_item,
    output t_status           o_status,
    output logic [CNT_W-1:0]  o_slack,
    output logic [SLOT_W-1:0] o_head_slot
);

    logic [SLOT_W-1:0] mem [POOL_DEPTH];
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [SLOT_W-1:0] r_rdata;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_pop, w_push;

    function automatic logic [SLOT_W-1:0] f_wrap_inc(input logic [SLOT_W-1:0] p);
        return (p == SLOT_W'(POOL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] f_start_tail(input logic [CNT_W-1:0] n);
        return (n >= CNT_W'(POOL_DEPTH)) ? '0 : n[SLOT_W-1:0];
    endfunction

    always_comb begin
        w_pop    = 1'b0;
        w_push   = 1'b0;
        o_status = ST_DONE;
        if (i_item.mode == MODE_ALLOC) begin
            if (r_count == '0) o_status = ST_EMPTY;
            else w_pop = 1'b1;
        end else begin
            if (!i_item.handle_valid || CNT_W'(i_item.free_index) >= i_live_count ||
                r_count >= i_live_count) begin
                o_status = ST_IGNORED;
            end else begin
                w_push = 1'b1;
            end
        end
    end

    always_comb begin
        if (w_pop) o_slack = r_count - 1'b1;
        else if (w_push) o_slack = r_count + 1'b1;
        else o_slack = r_count;
        n_head  = (i_take && w_pop)  ? f_wrap_inc(r_head) : r_head;
        n_tail  = (i_take && w_push) ? f_wrap_inc(r_tail) : r_tail;
        n_count = i_take ? o_slack : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= f_start_tail(RESET_COUNT);
            r_count <= RESET_COUNT;
        end else if (i_init) begin
            r_head  <= '0;
            r_tail  <= f_start_tail(i_init_count);
            r_count <= i_init_count;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Sweep loads slot i at position i; pops read the head position.
    always_ff @(posedge i_clk) begin
        if (i_clr.active) mem[i_clr.idx] <= i_clr.idx;
        else if (i_take && w_push) mem[r_tail] <= i_item.free_index;
        if (i_take) r_rdata <= mem[r_head];
    end

    assign o_head_slot = r_rdata;

endmodule

// ----- sv/dfl_rev_store.sv -----
// Per-slot revision memory with read-modify-write and same-edge forwarding.
module dfl_rev_store import dfl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_clr              i_clr,
    input  logic              i_rd_en,
    input  logic [SLOT_W-1:0] i_rd_slot,
    input  logic              i_wr_en,
    input  logic [SLOT_W-1:0] i_wr_slot,
    output logic [REV_W-1:0]  o_rev_next
);

    logic [REV_W-1:0] mem [POOL_DEPTH];
    logic [REV_W-1:0] r_rdata;
    logic [REV_W-1:0] r_last;
    logic             r_bypass;

    // A read that lands on the edge of a write to the same slot is forwarded the written revision.
    assign o_rev_next = (r_bypass ? r_last : r_rdata) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_clr.active) mem[i_clr.idx] <= '0;
        else if (i_wr_en) mem[i_wr_slot] <= o_rev_next;
        if (i_rd_en) r_rdata <= mem[i_rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_last <= o_rev_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass <= 1'b0;
        end else if (i_rd_en) begin
            r_bypass <= i_wr_en && (i_rd_slot == i_wr_slot);
        end
    end

endmodule

// ----- sv/descriptor_free_list_allocator.sv -----
// Top level of the descriptor free list allocator.
// Usage:
//   Request channel i_in_valid / o_in_stall / i_in_data: allocate (mode 0) or free
//   (mode 1). Result channel o_out_valid / i_out_stall / o_out_data: one result per
//   request with status, slot, revision, cpu_address and free count (slack).
//   Config port i_cfg_we / i_cfg_idx / i_cfg_wdata: 0 heap_start, 1 increment_size,
//   2 descriptor_count; write only while no request is in flight.
// Timing:
//   A request passes the stage 1, stage 2 and output registers; throughput is
//   one request per cycle while neither stall is raised. The stages come from
//   the registered read of the free queue memory and the revision memory
//   read-modify-write, which forwards a revision written on the edge of the read.
// Reset and reinit:
//   After reset, and after each descriptor_count write, a clearing pass over all
//   1024 slots loads the queue with slots in order and zeroes the revisions;
//   o_in_stall is high during it. Config writes are still taken.
// Backpressure:
//   When i_out_stall holds a result, the pipeline keeps up to two more requests
//   and o_in_stall rises once all stages are full.
`include "assert_macros.svh"
module descriptor_free_list_allocator import dfl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [ADDR_W-1:0] r_heap;
    logic [INC_W-1:0]  r_inc;
    logic [CNT_W-1:0]  r_live;
    logic [CNT_W-1:0]  w_cfg_count;
    logic              w_init;

    t_clr              r_clr;

    logic              r_v1, r_v2, r_o_valid;
    t_s1               r_s1;
    t_s2               r_s2;
    t_out              r_out, w_out;

    logic              w_en_o, w_en2, w_en1, w_accept;
    t_status           w_status;
    logic [CNT_W-1:0]  w_slack;
    logic [SLOT_W-1:0] w_head_slot;
    logic [SLOT_W-1:0] w_s1_slot;
    logic              w_rev_wr;
    logic [REV_W-1:0]  w_rev_next;
    logic [INC_W+SLOT_W-1:0] w_offset;
    logic [ADDR_W-1:0] w_addr;
    logic              w_alloc_done;

    // ---------------- configuration ----------------
    assign w_cfg_count = (i_cfg_wdata[CNT_W-1:0] > CNT_W'(POOL_DEPTH)) ?
                         CNT_W'(POOL_DEPTH) : i_cfg_wdata[CNT_W-1:0];
    assign w_init      = i_cfg_we && (i_cfg_idx == REG_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap <= '0;
            r_inc  <= RESET_INC;
            r_live <= RESET_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HEAP_START: r_heap <= i_cfg_wdata[ADDR_W-1:0];
                REG_INCREMENT:  r_inc  <= i_cfg_wdata[INC_W-1:0];
                REG_COUNT:      r_live <= w_cfg_count;
                default: ;
            endcase
        end
    end

    // Clearing sweep over both memories.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_init) begin
            r_clr.active <= 1'b1;
            r_clr.idx    <= '0;
        end else if (r_clr.active) begin
            if (r_clr.idx == SLOT_W'(POOL_DEPTH - 1)) r_clr.active <= 1'b0;
            r_clr.idx <= r_clr.idx + 1'b1;
        end
    end

    // ---------------- pipeline control ----------------
    assign w_en_o     = !r_o_valid || !i_out_stall;
    assign w_en2      = !r_v2 || w_en_o;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_stall = !w_en1 || r_clr.active;
    assign w_accept   = i_in_valid && !o_in_stall;

    dfl_free_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr        (r_clr),
        .i_init       (w_init),
        .i_init_count (w_cfg_count),
        .i_live_count (r_live),
        .i_take       (w_accept),
        .i_item       (i_in_data),
        .o_status     (w_status),
        .o_slack      (w_slack),
        .o_head_slot  (w_head_slot)
    );

    assign w_s1_slot = r_s1.is_alloc ? w_head_slot : r_s1.free_index;
    assign w_rev_wr  = r_v2 && w_en_o && (r_s2.status == ST_DONE);

    dfl_rev_store u_rev (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (r_clr),
        .i_rd_en    (r_v1 && w_en2),
        .i_rd_slot  (w_s1_slot),
        .i_wr_en    (w_rev_wr),
        .i_wr_slot  (r_s2.slot),
        .o_rev_next (w_rev_next)
    );

    // ---------------- result formation ----------------
    assign w_offset     = (INC_W+SLOT_W)'(r_inc) * (INC_W+SLOT_W)'(r_s2.slot);
    assign w_addr       = r_heap + ADDR_W'(w_offset);
    assign w_alloc_done = r_s2.is_alloc && (r_s2.status == ST_DONE);

    always_comb begin
        w_out.status      = r_s2.status;
        w_out.slot        = w_alloc_done ? r_s2.slot : '0;
        w_out.revision    = (r_s2.status == ST_DONE) ? w_rev_next : '0;
        w_out.cpu_address = w_alloc_done ? w_addr : '0;
        w_out.slack       = r_s2.slack;
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_en1)  r_v1      <= w_accept;
            if (w_en2)  r_v2      <= r_v1;
            if (w_en_o) r_o_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1.is_alloc   <= (i_in_data.mode == MODE_ALLOC);
            r_s1.status     <= w_status;
            r_s1.free_index <= i_in_data.free_index;
            r_s1.slack      <= w_slack;
        end
        if (w_en2) begin
            r_s2.is_alloc <= r_s1.is_alloc;
            r_s2.status   <= r_s1.status;
            r_s2.slot     <= w_s1_slot;
            r_s2.slack    <= r_s1.slack;
        end
        if (w_en_o) r_out <= w_out;
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    `DFL_ASSERT_IMP(a_empty_slack, o_out_valid && (o_out_data.status == ST_EMPTY),
        o_out_data.slack == '0, "allocate on empty pool reported nonzero free count")
    `DFL_ASSERT_IMP(a_ignored_zero, o_out_valid && (o_out_data.status == ST_IGNORED),
        (o_out_data.slot == '0) && (o_out_data.revision == '0) &&
        (o_out_data.cpu_address == '0), "ignored free returned nonzero payload")
    `DFL_ASSERT_IMP(a_slack_bound, o_out_valid, o_out_data.slack <= r_live,
        "free count exceeds descriptor count")
    `DFL_ASSERT_NXT(a_init_clears, w_init, r_clr.active && (r_clr.idx == '0),
        "descriptor_count write did not start the clearing pass")

endmodule
